### rtl/core/utf8d_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package utf8d_pkg;

	typedef enum logic [1:0] {
		MODE_LEAD = 2'd0,
		MODE_NEED = 2'd1,
		MODE_BAD  = 2'd2
	} mode_t;

	localparam int unsigned CP_W = 21;

	localparam logic [7:0]  ASCII_MAX   = 8'h7F;
	localparam logic [7:0]  LEAD2_MIN   = 8'hC0;
	localparam logic [7:0]  LEAD2_MAX   = 8'hDF;
	localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
	localparam logic [7:0]  LEAD3_MAX   = 8'hEF;
	localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
	localparam logic [7:0]  LEAD4_MAX   = 8'hF4;
	localparam logic [7:0]  CONT_MIN    = 8'h80;
	localparam logic [7:0]  CONT_MAX    = 8'hBF;
	localparam logic [CP_W-1:0] BMP_MAX  = 21'h00FFFF;
	localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;
	localparam logic [15:0] HI_SURR     = 16'hD800;
	localparam logic [15:0] LO_SURR     = 16'hDC00;
	localparam logic [5:0]  HI_SURR_TAG = 6'b110110;

	// One output word.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        unit_valid;
		logic        bad_input;
		logic        end_mark;
		logic        end_ok;
		logic        last;
	} result_t;

endpackage

### rtl/core/utf8_to_utf16_decoder.sv
// UTF-8 to UTF-16 decoder: one input byte per word, up to two code units out.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------------
//  input   | in_valid  | in_stall  | data_byte, byte_present, restart, finish
//  output  | out_valid | out_stall | code_unit, unit_valid, bad_input, end_mark,
//          |           |           | end_ok, last
//
// One input word per cycle while in_stall is low. A word is decoded in the cycle it
// is accepted and its first result shows in the output register in the next cycle. A
// surrogate pair parks its low half in a second register, so the input stalls while
// the low half moves to the output. in_stall also follows out_stall while the output
// register is full and held. Reset clears the decode state and empties both
// registers; the block takes input as soon as reset is released.
module utf8_to_utf16_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        restart,
	input  logic        finish,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] code_unit,
	output logic        unit_valid,
	output logic        bad_input,
	output logic        end_mark,
	output logic        end_ok,
	output logic        last
);

	// Decode state.
	utf8d_pkg::mode_t                mode_q;
	logic [utf8d_pkg::CP_W-1:0]      accum_q;
	logic [1:0]                      need_q;

	// Output register and the parked low surrogate.
	logic                            out_valid_q;
	utf8d_pkg::result_t              out_q;
	logic                            pend_valid_q;
	utf8d_pkg::result_t              pend_q;

	logic                            out_free;
	logic                            accept;

	// Decode of the current word.
	utf8d_pkg::mode_t                eff_mode;
	logic [utf8d_pkg::CP_W-1:0]      eff_accum;
	logic [1:0]                      eff_need;
	utf8d_pkg::mode_t                nxt_mode;
	logic [utf8d_pkg::CP_W-1:0]      nxt_accum;
	logic [1:0]                      nxt_need;
	logic [utf8d_pkg::CP_W-1:0]      cp;
	logic [utf8d_pkg::CP_W-1:0]      cp_off;
	logic [1:0]                      n_units;
	logic [15:0]                     unit0;
	logic [15:0]                     unit1;
	logic                            bad;
	logic                            any_result;
	logic                            two_results;
	utf8d_pkg::result_t              res0;
	utf8d_pkg::result_t              res1;

	// Output register is free when empty or when its word leaves this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = pend_valid_q || !out_free;
	assign accept   = in_valid && !in_stall;

	assign cp     = {accum_q[utf8d_pkg::CP_W-7:0], data_byte[5:0]};
	assign cp_off = cp - utf8d_pkg::SUPP_BASE;

	always_comb begin
		// Restart acts before the byte.
		eff_mode  = restart ? utf8d_pkg::MODE_LEAD : mode_q;
		eff_accum = restart ? '0 : accum_q;
		eff_need  = restart ? 2'd0 : need_q;
		nxt_mode  = eff_mode;
		nxt_accum = eff_accum;
		nxt_need  = eff_need;
		n_units   = 2'd0;
		unit0     = '0;
		unit1     = '0;
		bad       = 1'b0;

		if (byte_present) begin
			case (eff_mode)
				utf8d_pkg::MODE_LEAD: begin
					if (data_byte <= utf8d_pkg::ASCII_MAX) begin
						unit0   = {8'd0, data_byte};
						n_units = 2'd1;
					end else if (data_byte inside
						{[utf8d_pkg::LEAD2_MIN:utf8d_pkg::LEAD2_MAX]}) begin
						nxt_accum = {16'd0, data_byte[4:0]};
						nxt_need  = 2'd1;
						nxt_mode  = utf8d_pkg::MODE_NEED;
					end else if (data_byte inside
						{[utf8d_pkg::LEAD3_MIN:utf8d_pkg::LEAD3_MAX]}) begin
						nxt_accum = {17'd0, data_byte[3:0]};
						nxt_need  = 2'd2;
						nxt_mode  = utf8d_pkg::MODE_NEED;
					end else if (data_byte inside
						{[utf8d_pkg::LEAD4_MIN:utf8d_pkg::LEAD4_MAX]}) begin
						nxt_accum = {18'd0, data_byte[2:0]};
						nxt_need  = 2'd3;
						nxt_mode  = utf8d_pkg::MODE_NEED;
					end else begin
						bad = 1'b1;
					end
				end
				utf8d_pkg::MODE_NEED: begin
					if (!(data_byte inside
						{[utf8d_pkg::CONT_MIN:utf8d_pkg::CONT_MAX]})) begin
						bad = 1'b1;
					end else begin
						// cp is the accumulator with six more bits shifted in.
						nxt_accum = {eff_accum[utf8d_pkg::CP_W-7:0], data_byte[5:0]};
						nxt_need  = eff_need - 2'd1;
						if (eff_need == 2'd1) begin
							if (nxt_accum <= utf8d_pkg::BMP_MAX) begin
								unit0    = nxt_accum[15:0];
								n_units  = 2'd1;
								nxt_mode = utf8d_pkg::MODE_LEAD;
							end else if (nxt_accum <= utf8d_pkg::CP_MAX) begin
								unit0    = utf8d_pkg::HI_SURR | {6'd0, cp_off[19:10]};
								unit1    = utf8d_pkg::LO_SURR | {6'd0, cp_off[9:0]};
								n_units  = 2'd2;
								nxt_mode = utf8d_pkg::MODE_LEAD;
							end else begin
								bad = 1'b1;
							end
						end
					end
				end
				default: begin
					// Bad state: drop the byte.
				end
			endcase
			if (bad) begin
				nxt_mode = utf8d_pkg::MODE_BAD;
			end
		end

		any_result  = (n_units != 2'd0) || bad || finish;
		two_results = (n_units == 2'd2);

		// First result; carries the flags unless a second unit follows.
		res0.code_unit  = unit0;
		res0.unit_valid = (n_units != 2'd0);
		res0.bad_input  = !two_results && bad;
		res0.end_mark   = !two_results && finish;
		res0.end_ok     = !two_results && finish && (nxt_mode == utf8d_pkg::MODE_LEAD);
		res0.last       = !two_results;

		res1.code_unit  = unit1;
		res1.unit_valid = 1'b1;
		res1.bad_input  = 1'b0;
		res1.end_mark   = finish;
		res1.end_ok     = finish && (nxt_mode == utf8d_pkg::MODE_LEAD);
		res1.last       = 1'b1;

		// Finish clears the state after the report.
		if (finish) begin
			nxt_mode  = utf8d_pkg::MODE_LEAD;
			nxt_accum = '0;
			nxt_need  = 2'd0;
		end
	end

	// Advance decode state on every accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= utf8d_pkg::MODE_LEAD;
			accum_q <= '0;
			need_q  <= 2'd0;
		end else if (accept) begin
			mode_q  <= nxt_mode;
			accum_q <= nxt_accum;
			need_q  <= nxt_need;
		end
	end

	// Output control: parked low half goes first, then a fresh word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (out_free) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= accept && any_result;
				pend_valid_q <= accept && two_results;
			end
		end
	end

	// Payload registers, no reset.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (accept) begin
				out_q  <= res0;
				pend_q <= res1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign code_unit  = out_q.code_unit;
	assign unit_valid = out_q.unit_valid;
	assign bad_input  = out_q.bad_input;
	assign end_mark   = out_q.end_mark;
	assign end_ok     = out_q.end_ok;
	assign last       = out_q.last;

	// A parked low surrogate always sits behind a full output register.
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("low surrogate parked with empty output register");

	// Input holds off while a low surrogate is parked.
	a_pend_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> in_stall)
		else $error("input accepted while a low surrogate is parked");

	// Only a high surrogate can precede another result of the same word.
	a_not_last_is_high: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |->
			(unit_valid && code_unit[15:10] == utf8d_pkg::HI_SURR_TAG))
		else $error("non-final result is not a high surrogate");

	// Flags ride only on the final result of a word.
	a_flags_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (end_mark || bad_input)) |-> last)
		else $error("status flags on a non-final result");

	// A high surrogate is followed by the low half in the next output word.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=>
			(out_valid && unit_valid && last && code_unit[15:10] != utf8d_pkg::HI_SURR_TAG))
		else $error("low surrogate did not follow its high half");

endmodule

### tb/utf8d_sb_pkg.sv
// Scoreboard for the UTF-8 to UTF-16 decoder: decode predictor and result checker.
`timescale 1ns / 100ps

package utf8d_sb_pkg;
	import utf8d_pkg::*;

	class utf16_unit_scoreboard;
		mode_t           mode;
		logic [CP_W-1:0] accum;
		logic [1:0]      need;
		result_t         due_words[$];
		int unsigned     mismatches;
		int unsigned     live_words;

		function new();
			mismatches = 0;
			live_words = 0;
			clear_decode();
		endfunction

		function void clear_decode();
			mode = MODE_LEAD;
			accum = '0;
			need = '0;
		endfunction

		function bit stuck();
			return mode != MODE_LEAD && mode != MODE_NEED;
		endfunction

		function int unsigned pending();
			return due_words.size();
		endfunction

		// Decode one accepted input word and queue the code units it must produce.
		function void note_byte_word(logic [7:0] b, logic present, logic restart,
				logic finish);
			logic [15:0]     units[2];
			result_t         res[2];
			logic [CP_W-1:0] cp;
			int              n;
			int              k;
			bit              bad;
			n = 0;
			bad = 1'b0;
			if (restart)
				clear_decode();
			// words dropped in the bad state do not advance the stimulus count
			if ((present && !stuck()) || finish)
				live_words++;
			if (present) begin
				case (mode)
				MODE_LEAD: begin
					if (b <= ASCII_MAX) begin
						units[0] = {8'h00, b};
						n = 1;
					end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
						accum = {16'd0, b[4:0]};
						need = 2'd1;
						mode = MODE_NEED;
					end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
						accum = {17'd0, b[3:0]};
						need = 2'd2;
						mode = MODE_NEED;
					end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
						accum = {18'd0, b[2:0]};
						need = 2'd3;
						mode = MODE_NEED;
					end else begin
						bad = 1'b1;
					end
				end
				MODE_NEED: begin
					if (b < CONT_MIN || b > CONT_MAX) begin
						bad = 1'b1;
					end else begin
						accum = {accum[CP_W-7:0], b[5:0]};
						need = need - 2'd1;
						if (need == 2'd0) begin
							if (accum <= BMP_MAX) begin
								units[0] = accum[15:0];
								n = 1;
								mode = MODE_LEAD;
							end else if (accum <= CP_MAX) begin
								cp = accum - SUPP_BASE;
								units[0] = HI_SURR | {6'd0, cp[19:10]};
								units[1] = LO_SURR | {6'd0, cp[9:0]};
								n = 2;
								mode = MODE_LEAD;
							end else begin
								bad = 1'b1;
							end
						end
					end
				end
				default: ;
				endcase
				if (bad)
					mode = MODE_BAD;
			end

			for (k = 0; k < n; k++) begin
				res[k] = '0;
				res[k].code_unit = units[k];
				res[k].unit_valid = 1'b1;
			end
			if (n == 0 && (bad || finish)) begin
				res[0] = '0;
				n = 1;
			end
			if (n > 0) begin
				res[n-1].bad_input = bad;
				res[n-1].end_mark = finish;
				res[n-1].end_ok = finish && mode == MODE_LEAD;
				res[n-1].last = 1'b1;
			end
			for (k = 0; k < n; k++)
				due_words.push_back(res[k]);
			if (finish)
				clear_decode();
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $time, what);
			mismatches++;
		endtask

		task compare_field(string field, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %h want %h", field, got, want));
		endtask

		// Compare one accepted output word with the oldest queued expectation.
		task check_unit_word(result_t got);
			result_t want;
			if (due_words.size() == 0) begin
				report_mismatch($sformatf("output word %h with nothing queued", got));
				return;
			end
			want = due_words.pop_front();
			compare_field("code_unit", got.code_unit, want.code_unit);
			compare_field("unit_valid", {15'd0, got.unit_valid}, {15'd0, want.unit_valid});
			compare_field("bad_input", {15'd0, got.bad_input}, {15'd0, want.bad_input});
			compare_field("end_mark", {15'd0, got.end_mark}, {15'd0, want.end_mark});
			compare_field("end_ok", {15'd0, got.end_ok}, {15'd0, want.end_ok});
			compare_field("last", {15'd0, got.last}, {15'd0, want.last});
		endtask
	endclass

endpackage

### tb/tb.sv
// Top-level testbench for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 100ps

module tb;
	import utf8d_pkg::*;
	import utf8d_sb_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned PHASE_WORDS  = 500;
	localparam int unsigned SETTLE_TICKS = 8;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        byte_present;
	logic        restart;
	logic        finish;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] code_unit;
	logic        unit_valid;
	logic        bad_input;
	logic        end_mark;
	logic        end_ok;
	logic        last;

	int unsigned in_idle_pct = 0;
	int unsigned out_stall_pct = 0;
	int unsigned cycle_count = 0;

	utf16_unit_scoreboard sb;

	utf8_to_utf16_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.restart      (restart),
		.finish       (finish),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code_unit    (code_unit),
		.unit_valid   (unit_valid),
		.bad_input    (bad_input),
		.end_mark     (end_mark),
		.end_ok       (end_ok),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: end the run if the block stops making progress.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due",
				cycle_count, sb.pending());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: raise stall at random on the falling edge, at the current phase rate.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < out_stall_pct);

	// Sample both channels at the rising edge; inputs only move on the falling edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_byte_word(data_byte, byte_present, restart, finish);
			if (out_valid && !out_stall)
				sb.check_unit_word({code_unit, unit_valid, bad_input, end_mark, end_ok,
					last});
		end
	end

	// Present one word, entered and left on a falling edge. Idle first at the
	// phase rate, then hold the word until the rising edge that accepts it.
	task automatic drive_word(logic [7:0] b, logic present, logic rst, logic fin);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		data_byte    <= b;
		byte_present <= present;
		restart      <= rst;
		finish       <= fin;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every queued unit has come out.
	task automatic drain_units();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Top value of each sequence length, the last surrogate pair and every error path.
	task automatic run_directed();
		drive_word(8'h00, 1'b1, 1'b0, 1'b0);
		drive_word(ASCII_MAX, 1'b1, 1'b0, 1'b0);
		// largest two-byte value
		drive_word(LEAD2_MAX, 1'b1, 1'b0, 1'b0);
		drive_word(CONT_MAX, 1'b1, 1'b0, 1'b0);
		// largest three-byte value
		drive_word(LEAD3_MAX, 1'b1, 1'b0, 1'b0);
		drive_word(CONT_MAX, 1'b1, 1'b0, 1'b0);
		drive_word(CONT_MAX, 1'b1, 1'b0, 1'b0);
		// top of the code space: last surrogate pair
		drive_word(LEAD4_MAX, 1'b1, 1'b0, 1'b0);
		drive_word(8'h8F, 1'b1, 1'b0, 1'b0);
		drive_word(CONT_MAX, 1'b1, 1'b0, 1'b0);
		drive_word(CONT_MAX, 1'b1, 1'b0, 1'b0);
		// one past the top: value too large goes bad
		drive_word(LEAD4_MAX, 1'b1, 1'b0, 1'b0);
		drive_word(8'h90, 1'b1, 1'b0, 1'b0);
		drive_word(CONT_MIN, 1'b1, 1'b0, 1'b0);
		drive_word(CONT_MIN, 1'b1, 1'b0, 1'b0);
		// byte while bad is dropped silently
		drive_word(8'h41, 1'b1, 1'b0, 1'b0);
		// restart, then a bad lead byte
		drive_word(8'hFF, 1'b1, 1'b1, 1'b0);
		// restart, then a bad continuation
		drive_word(8'hC3, 1'b1, 1'b1, 1'b0);
		drive_word(8'h41, 1'b1, 1'b0, 1'b0);
		// restart with a finish and no byte: clean end
		drive_word(8'h00, 1'b0, 1'b1, 1'b1);
		// finish with a sequence pending
		drive_word(LEAD3_MIN, 1'b1, 1'b0, 1'b0);
		drive_word(8'h00, 1'b0, 1'b0, 1'b1);
		// bad lead byte on the finish word itself
		drive_word(CONT_MIN, 1'b1, 1'b0, 1'b1);
		// restart, lead byte and finish in one word
		drive_word(LEAD4_MIN, 1'b1, 1'b1, 1'b1);
		drive_word(8'h41, 1'b1, 1'b0, 1'b1);
	endtask

	// Send one random sequence: mostly well-formed with random content, the rest
	// truncated sequences and raw noise. Stray finish and byte-less words mix in.
	task automatic send_random_sequence();
		logic [7:0]  seq[$];
		int unsigned kind;
		int unsigned conts;
		int unsigned i;
		logic        rst;
		kind = $urandom_range(99);
		conts = 0;
		if (kind < 25) begin
			seq.push_back(8'($urandom_range(ASCII_MAX, 0)));
		end else if (kind < 45) begin
			seq.push_back(8'($urandom_range(LEAD2_MAX, LEAD2_MIN)));
			conts = 1;
		end else if (kind < 65) begin
			seq.push_back(8'($urandom_range(LEAD3_MAX, LEAD3_MIN)));
			conts = 2;
		end else if (kind < 80) begin
			seq.push_back(8'($urandom_range(LEAD4_MAX, LEAD4_MIN)));
			conts = 3;
		end else if (kind < 90) begin
			// truncated: cut the sequence short and follow it with anything
			seq.push_back(8'($urandom_range(LEAD4_MAX, LEAD2_MIN)));
			conts = $urandom_range(1, 0);
		end else begin
			seq.push_back(8'($urandom_range(255, 0)));
		end
		for (i = 0; i < conts; i++)
			seq.push_back(8'($urandom_range(CONT_MAX, CONT_MIN)));
		if (kind >= 80 && kind < 90)
			seq.push_back(8'($urandom_range(255, 0)));

		// leave a bad state quickly most of the time
		rst = sb.stuck() ? ($urandom_range(3) != 0) : ($urandom_range(24) == 0);
		for (i = 0; i < seq.size(); i++) begin
			drive_word(seq[i], $urandom_range(39) != 0, (i == 0) ? rst : 1'b0,
				$urandom_range(49) == 0);
		end
	endtask

	task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
		int unsigned target;
		in_idle_pct = idle_pct;
		out_stall_pct = stall_pct;
		target = sb.live_words + PHASE_WORDS;
		while (sb.live_words < target)
			send_random_sequence();
		drive_word(8'($urandom_range(255, 0)), 1'b0, 1'b0, 1'b1);
		drain_units();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		byte_present = 1'b0;
		restart = 1'b0;
		finish = 1'b0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Slow receiver first, with an occasional gap from the sender.
		in_idle_pct = 9;
		out_stall_pct = 83;
		run_directed();
		drain_units();
		run_phase(9, 83);
		// Then a slow sender against a mostly ready receiver, then full rate.
		run_phase(83, 9);
		run_phase(0, 0);

		out_stall_pct = 0;
		drain_units();
		repeat (SETTLE_TICKS) @(negedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
